/* rtl/ste_pkg.sv */
// Shared types and constants of the skew edge-ID table.
// No dependencies; imported by every module of the block but ste_ram.
package ste_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int ID_BITS_DEF   = 16;

    localparam int OP_W         = 2;
    localparam int NODE_W       = 11;
    localparam int EDGE_ID_W    = 17;
    localparam int EDGE_COUNT_W = 16;
    localparam int CFG_W        = 9;

    typedef enum logic [OP_W-1:0] {
        OP_GET = 2'd0,
        OP_ADD = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // capture the input beat
        logic look;        // issue the store read, latch the slot address
        logic commit;      // apply the update and load the output register
        logic clear_step;  // write zero at the clear pointer and advance it
    } ste_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;  // clear pointer sits on the last entry
        logic out_free;    // output register can take a result this cycle
    } ste_sts_t;

endpackage

/* rtl/ste_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ste_ctl.sv */
// Controller of the skew edge-ID table: clear pass, accept, look-up, commit.
// Depends on ste_pkg for the command and status structs.
module ste_ctl import ste_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ste_sts_t sts,
    output ste_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOK   = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // hold the read data until the output register frees up
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/ste_dp.sv */
// Datapath of the skew edge-ID table: item registers, slot address, edge store,
// edge counter, node count and output register. Depends on ste_pkg and ste_ram.
module ste_dp import ste_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ste_cmd_t                       cmd,
    output ste_sts_t                       sts,
    input  logic [OP_W-1:0]                s_op,
    input  logic signed [NODE_W-1:0]       s_node_a,
    input  logic signed [NODE_W-1:0]       s_node_b,
    input  logic                           cfg_we,
    input  logic [CFG_W-1:0]               cfg_wdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [EDGE_ID_W-1:0]    m_edge_id,
    output logic                           m_found,
    output logic [EDGE_COUNT_W-1:0]        m_edge_count,
    output logic                           m_error
);

    localparam int DEPTH = MAX_NODES * (MAX_NODES - 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NB    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int NC_W  = $clog2(MAX_NODES + 1);
    localparam int SW    = ID_BITS + 1;   // stored entry width
    localparam int IW    = ID_BITS + 2;   // oriented id width
    localparam int PW    = 2 * NB;

    // item registers
    op_t                     op_reg;
    logic signed [NODE_W-1:0] a_reg, b_reg;
    logic [AW-1:0]           addr_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic [ID_BITS-1:0]      counter_reg, counter_next;
    logic [NC_W-1:0]         node_count_reg, node_count_next;

    logic                    m_valid_reg;
    logic signed [EDGE_ID_W-1:0] m_edge_id_reg;
    logic                    m_found_reg;
    logic [EDGE_COUNT_W-1:0] m_edge_count_reg;
    logic                    m_error_reg;

    // pair decode
    logic                    a_gt_b, self_loop, lo_neg, in_range, hi_too_big, ctr_full;
    logic signed [NODE_W-1:0] hi, lo;
    logic [NODE_W-2:0]       hi_u, lo_u;
    logic [NB-1:0]           hi_idx, lo_idx;
    logic [PW-1:0]           prod;
    logic [AW-1:0]           slot_addr;

    logic signed [SW-1:0]    rd_data;
    logic signed [IW-1:0]    oriented, id_cur, res_id;
    logic [ID_BITS-1:0]      ctr_inc;
    logic signed [SW-1:0]    store_val;
    logic                    res_found, res_err, bump, store_we, grow;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [SW-1:0]           ram_wdata;
    logic [SW-1:0]           ram_rdata;

    logic [31:0]             cfg_lim;

    assign a_gt_b    = a_reg > b_reg;
    assign self_loop = a_reg == b_reg;
    assign hi        = a_gt_b ? a_reg : b_reg;
    assign lo        = a_gt_b ? b_reg : a_reg;
    assign lo_neg    = lo[NODE_W-1];
    assign hi_u      = hi[NODE_W-2:0];
    assign lo_u      = lo[NODE_W-2:0];
    assign hi_idx    = hi_u[NB-1:0];
    assign lo_idx    = lo_u[NB-1:0];

    // lower-triangle slot: hi*(hi-1)/2 + lo
    assign prod      = PW'(hi_idx) * PW'(hi_idx - 1'b1);
    assign slot_addr = AW'((prod >> 1) + PW'(lo_idx));

    assign in_range   = !lo_neg && !self_loop && (32'(hi_u) < 32'(node_count_reg));
    assign hi_too_big = 32'(hi_u) >= 32'(MAX_NODES);
    assign ctr_full   = &counter_reg;
    assign ctr_inc    = counter_reg + 1'b1;

    assign rd_data  = $signed(ram_rdata);
    assign oriented = a_gt_b ? IW'(rd_data) : -IW'(rd_data);
    assign id_cur   = in_range ? oriented : '0;

    always_comb begin
        res_id    = '0;
        res_found = 1'b0;
        res_err   = 1'b0;
        bump      = 1'b0;
        store_we  = 1'b0;
        store_val = '0;
        grow      = 1'b0;
        case (op_reg)
            OP_GET: begin
                res_id    = id_cur;
                res_found = id_cur != '0;
            end
            OP_ADD: begin
                if (lo_neg || self_loop) begin
                    // counter bump only, nothing stored
                    if (ctr_full) begin
                        res_err = 1'b1;
                    end else begin
                        bump   = 1'b1;
                        res_id = $signed({2'b00, ctr_inc});
                    end
                end else if (id_cur != '0) begin
                    res_id    = id_cur;
                    res_found = 1'b1;
                end else if (hi_too_big || ctr_full) begin
                    res_err = 1'b1;
                end else begin
                    bump      = 1'b1;
                    grow      = 1'b1;
                    store_we  = 1'b1;
                    store_val = a_gt_b ? $signed({1'b0, ctr_inc}) : -$signed({1'b0, ctr_inc});
                    res_id    = $signed({2'b00, ctr_inc});
                end
            end
            OP_DEL: begin
                store_we = in_range;
            end
            default: begin
            end
        endcase
    end

    assign ram_we    = cmd.clear_step || (cmd.commit && store_we);
    assign ram_waddr = cmd.clear_step ? clr_addr_reg : addr_reg;
    assign ram_wdata = cmd.clear_step ? '0 : store_val;

    ste_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.look),
        .raddr (slot_addr),
        .rdata (ram_rdata)
    );

    // item capture and slot address
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= op_t'(s_op);
            a_reg  <= s_node_a;
            b_reg  <= s_node_b;
        end
        if (cmd.look) begin
            addr_reg <= slot_addr;
        end
    end

    assign cfg_lim = (32'(cfg_wdata) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(cfg_wdata);

    always_comb begin
        counter_next    = counter_reg;
        node_count_next = node_count_reg;
        if (cmd.commit && bump) begin
            counter_next = ctr_inc;
        end
        if (cmd.commit && grow && (32'(hi_u) >= 32'(node_count_reg))) begin
            node_count_next = NC_W'(32'(hi_u) + 32'd1);
        end
        if (cfg_we && (cfg_lim > 32'(node_count_reg))) begin
            node_count_next = NC_W'(cfg_lim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            counter_reg    <= '0;
            node_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            counter_reg    <= counter_next;
            node_count_reg <= node_count_next;
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_edge_id_reg    <= EDGE_ID_W'(res_id);
            m_found_reg      <= res_found;
            m_edge_count_reg <= EDGE_COUNT_W'(counter_next);
            m_error_reg      <= res_err;
        end
    end

    assign sts.clear_last = clr_addr_reg == AW'(DEPTH - 1);
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_edge_id    = m_edge_id_reg;
    assign m_found      = m_found_reg;
    assign m_edge_count = m_edge_count_reg;
    assign m_error      = m_error_reg;

endmodule

/* rtl/skew_edge_id_table.sv */
// Top level of the skew edge-ID table; joins ste_ctl and ste_dp (uses ste_pkg, ste_ram).
// Each item passes through accept, store read and commit, and a new beat is taken only
// after that commit, set by the read-modify-write through the registered store read.
// Reset (aresetn low, synchronous): counter, node count and valids clear, then a clear
// pass writes zero to all MAX_NODES*(MAX_NODES-1)/2 entries, one a cycle (32640 entries
// at the default), with s_ready low; initial_nodes writes are taken during the pass.
module skew_edge_id_table import ste_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input beat: operation and node pair
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [OP_W-1:0]             s_op,
    input  logic signed [NODE_W-1:0]    s_node_a,
    input  logic signed [NODE_W-1:0]    s_node_b,
    // initial_nodes register
    input  logic                        cfg_we,
    input  logic [CFG_W-1:0]            cfg_wdata,
    // result beat
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [EDGE_ID_W-1:0] m_edge_id,
    output logic                        m_found,
    output logic [EDGE_COUNT_W-1:0]     m_edge_count,
    output logic                        m_error
);

    ste_cmd_t cmd;
    ste_sts_t sts;

    // Controller: sequence the clear pass, then accept one beat, read its slot,
    // and commit once the output register can take the result.
    ste_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: hold the item, form the triangle slot, read and update the store,
    // advance the edge counter, grow the node count, and register the result.
    // The output register parts the sides: a new beat is taken while a result waits.
    ste_dp #(
        .MAX_NODES (MAX_NODES),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_op         (s_op),
        .s_node_a     (s_node_a),
        .s_node_b     (s_node_b),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_id    (m_edge_id),
        .m_found      (m_found),
        .m_edge_count (m_edge_count),
        .m_error      (m_error)
    );

endmodule

/* rtl/ste_checker.sv */
// Port-level checks of the skew edge-ID table, bound to the top level.
// Depends on ste_pkg for field widths.
module ste_checker import ste_pkg::*; (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [EDGE_ID_W-1:0] m_edge_id,
    input logic                        m_found,
    input logic [EDGE_COUNT_W-1:0]     m_edge_count,
    input logic                        m_error
);

    // after reset nothing is offered and nothing is taken (clear pass follows)
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or ready shown right after reset");

    // one input beat at a time: ready drops right after a beat is taken
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back-to-back cycles");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_edge_id) && $stable(m_edge_count)
            && $stable(m_found) && $stable(m_error))
        else $error("stalled result beat changed");

    // found implies a nonzero id
    a_found_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_edge_id != '0)
        else $error("found set with zero edge id");

    // a refused add reports no id and no hit
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_edge_id == '0 && !m_found)
        else $error("error result carries an edge id");

endmodule

bind skew_edge_id_table ste_checker u_ste_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_edge_id    (m_edge_id),
    .m_found      (m_found),
    .m_edge_count (m_edge_count),
    .m_error      (m_error)
);
